[src/dwa_pkg.sv]
// Shared types, constants and command/status structs of the decayed window average block.
package dwa_pkg;

  localparam int WINDOW_MAX  = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = $clog2(WINDOW_MAX);
  localparam int FILL_W      = 5;
  localparam int WEIGHT_W    = 16;
  localparam int FRAC_BITS   = 15;
  localparam int PROD_W      = SAMPLE_BITS + WEIGHT_W + 1;
  localparam int ACC_W       = PROD_W + IDX_W;
  localparam int MAG_W       = ACC_W - FRAC_BITS;
  localparam int DCNT_W      = $clog2(MAG_W);
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;

  localparam logic [WEIGHT_W-1:0]  Q_ONE      = WEIGHT_W'(1 << FRAC_BITS);
  localparam logic [FILL_W-1:0]    FILL_MAX   = FILL_W'(WINDOW_MAX);
  localparam logic [DCNT_W-1:0]    DIV_LAST   = DCNT_W'(MAG_W - 1);
  localparam logic [MAG_W-1:0]     POS_LIMIT  = MAG_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [MAG_W-1:0]     NEG_LIMIT  = MAG_W'(1 << (SAMPLE_BITS - 1));

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DECAY         = CFG_IDX_W'(1);

  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  typedef struct packed {
    logic                          command;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic [FILL_W-1:0]             held;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mac_step;
    logic flush;
    logic prep;
    logic div_step;
    logic finish;
  } dwa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic mac_last;
    logic div_last;
  } dwa_status_t;

endpackage

[src/decayed_window_average.sv]
// Top level of the decayed window average block.
// Each input word either pushes a signed sample into a window of up to 16 newest samples or
// clears the window; each produces one result word with the decay-weighted average and the
// number of samples held. An item passes a start state, one multiply-accumulate per held sample
// (none for an empty window or a clear, which go straight to the output load), a flush state
// and a divider setup state, then a restoring divider that yields one quotient bit per cycle,
// and a final state that loads the output register; it waits while an earlier result is unread.
// One item is processed at a time; a new word is taken as soon as the previous result has been
// moved into the output register, even while that result still waits to be read.
module decayed_window_average (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dwa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dwa_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dwa_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dwa_pkg::out_word_t            out_word_o
);
  import dwa_pkg::*;

  dwa_cmd_t    cmd;
  dwa_status_t status;

  dwa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dwa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_word_o  (out_word_o)
  );

endmodule

[src/dwa_datapath.sv]
// Datapath: configuration, sample history, serial weighted sum and serial divider.
module dwa_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dwa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dwa_pkg::CFG_W-1:0]         cfg_data_i,
  input  dwa_pkg::in_word_t                 in_word_i,
  input  dwa_pkg::dwa_cmd_t                 cmd_i,
  output dwa_pkg::dwa_status_t              status_o,
  output dwa_pkg::out_word_t                out_word_o
);
  import dwa_pkg::*;

  logic [FILL_W-1:0]             wl_q;
  logic [WEIGHT_W-1:0]           decay_q;
  logic signed [SAMPLE_BITS-1:0] hist_q [WINDOW_MAX];
  logic [FILL_W-1:0]             fill_q, fill_d;
  logic [IDX_W-1:0]              k_q;
  logic [WEIGHT_W-1:0]           w_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic                          prod_v_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic                          neg_q;
  logic [MAG_W-1:0]              quot_q;
  logic [FILL_W-1:0]             rem_q;
  logic [DCNT_W-1:0]             dcnt_q;
  out_word_t                     res_q;

  logic [FILL_W-1:0]             len;
  logic [FILL_W-1:0]             fill_inc;
  logic [WEIGHT_W-1:0]           dsat;
  logic [2*WEIGHT_W-1:0]         w_prod;
  logic signed [PROD_W-1:0]      mult;
  logic [ACC_W-1:0]              acc_abs;
  logic [FILL_W:0]               trial;
  logic                          qbit;
  logic signed [SAMPLE_BITS-1:0] avg;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q    <= FILL_MAX;
      decay_q <= Q_ONE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WINDOW_LENGTH: wl_q    <= cfg_data_i[FILL_W-1:0];
        REG_DECAY:         decay_q <= cfg_data_i[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len      = (wl_q > FILL_MAX) ? FILL_MAX : wl_q;
    fill_inc = (fill_q < FILL_MAX) ? fill_q + FILL_W'(1) : fill_q;
    fill_d   = fill_q;
    if (cmd_i.load) begin
      if (in_word_i.command == CMD_CLEAR) begin
        fill_d = '0;
      end else begin
        fill_d = (fill_inc > len) ? len : fill_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // History shift register, newest sample at index 0.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_word_i.command == CMD_MEASURE) begin
      hist_q[0] <= in_word_i.sample;
      for (int i = 1; i < WINDOW_MAX; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  // One sample times weight per cycle; the weight power advances alongside.
  always_comb begin
    dsat   = (decay_q > Q_ONE) ? Q_ONE : decay_q;
    w_prod = w_q * dsat;
    mult   = hist_q[k_q] * $signed({1'b0, w_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else if (cmd_i.load || cmd_i.flush) begin
      prod_v_q <= 1'b0;
    end else if (cmd_i.mac_step) begin
      prod_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      k_q   <= '0;
      w_q   <= Q_ONE;
      acc_q <= '0;
    end else begin
      if (cmd_i.mac_step) begin
        k_q    <= k_q + IDX_W'(1);
        w_q    <= w_prod[FRAC_BITS +: WEIGHT_W];
        prod_q <= mult;
      end
      if ((cmd_i.mac_step || cmd_i.flush) && prod_v_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  // Restoring divider: |acc| >> 15 divided by the count, one quotient bit per cycle.
  always_comb begin
    acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    trial   = {rem_q, quot_q[MAG_W-1]};
    qbit    = (trial >= {1'b0, fill_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      neg_q  <= acc_q[ACC_W-1];
      quot_q <= acc_abs[ACC_W-1:FRAC_BITS];
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= qbit ? FILL_W'(trial - {1'b0, fill_q}) : trial[FILL_W-1:0];
      quot_q <= {quot_q[MAG_W-2:0], qbit};
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
  end

  always_comb begin
    if (fill_q == '0) begin
      avg = '0;
    end else if (neg_q) begin
      avg = (quot_q > NEG_LIMIT) ? $signed(NEG_LIMIT[SAMPLE_BITS-1:0])
                                 : $signed(-quot_q[SAMPLE_BITS-1:0]);
    end else begin
      avg = (quot_q > POS_LIMIT) ? $signed(POS_LIMIT[SAMPLE_BITS-1:0])
                                 : $signed(quot_q[SAMPLE_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q.average <= avg;
      res_q.held    <= fill_q;
    end
  end

  assign status_o.empty    = (fill_q == '0);
  assign status_o.mac_last = ({1'b0, k_q} == FILL_W'(fill_q - FILL_W'(1)));
  assign status_o.div_last = (dcnt_q == DIV_LAST);
  assign out_word_o        = res_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX) else $error("fill count above window maximum");
  a_mac_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mac_step |-> ({1'b0, k_q} < fill_q)) else $error("history index past fill");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < fill_q)) else $error("divider remainder out of range");
`endif

endmodule

[src/dwa_ctrl.sv]
// Controller: sequences load, multiply-accumulate, divide and result handoff.
module dwa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  dwa_pkg::dwa_status_t  status_i,
  output dwa_pkg::dwa_cmd_t     cmd_o
);
  import dwa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_PREP  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        state_d = status_i.empty ? S_FIN : S_MAC;
      end
      S_MAC: begin
        cmd_o.mac_step = 1'b1;
        if (status_i.mac_last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_START) else $error("accepted word not started");
  a_finish_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> slot_free) else $error("result overwrote a pending word");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("more than one datapath command");
`endif

endmodule

[tb/dwa_checker.sv]
// Result checker for the decayed window average block: tracks the window and compares each word.
module dwa_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dwa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dwa_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  dwa_pkg::in_word_t             in_word_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  dwa_pkg::out_word_t            out_word_i,
  output int                            pending_o,
  output int                            errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import dwa_pkg::*;

  localparam int REPORT_MAX = 10;

  logic signed [SAMPLE_BITS-1:0] window_hist [WINDOW_MAX];
  int                            fill;
  logic [FILL_W-1:0]             win_len;
  logic [WEIGHT_W-1:0]           decay_q15;
  out_word_t                     expected_words [$];
  int                            fail_count;

  // Decay-weighted sum of the held samples over held, truncated toward zero and clamped.
  function automatic logic signed [SAMPLE_BITS-1:0] weighted_avg();
    longint acc = 0;
    longint weight = 32768;
    longint factor;
    longint quo;
    factor = (decay_q15 > Q_ONE) ? longint'(Q_ONE) : longint'(decay_q15);
    if (fill == 0) return '0;
    for (int k = 0; k < fill; k++) begin
      acc += longint'(window_hist[k]) * weight;
      weight = (weight * factor) >> FRAC_BITS;
    end
    quo = acc / (longint'(fill) * 32768);
    if (quo > 32767) quo = 32767;
    if (quo < -32768) quo = -32768;
    return quo[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    int        limit;
    if (!rst_ni) begin
      fill       = 0;
      win_len    = FILL_W'(16);
      decay_q15  = Q_ONE;
      fail_count = 0;
      expected_words.delete();
      pending_o  <= 0;
      errors_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WINDOW_LENGTH: win_len   = cfg_data_i[FILL_W-1:0];
          REG_DECAY:         decay_q15 = cfg_data_i[WEIGHT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("unexpected result word: average %0d held %0d",
                     out_word_i.average, out_word_i.held);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_word_i.average !== want.average || out_word_i.held !== want.held) begin
            if (fail_count < REPORT_MAX)
              $display("result mismatch: average exp %0d got %0d, held exp %0d got %0d",
                       want.average, out_word_i.average, want.held, out_word_i.held);
            fail_count++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (in_word_i.command == CMD_CLEAR) begin
          fill = 0;
        end else begin
          limit = (win_len > FILL_MAX) ? WINDOW_MAX : int'(win_len);
          for (int i = WINDOW_MAX - 1; i > 0; i--) window_hist[i] = window_hist[i-1];
          window_hist[0] = in_word_i.sample;
          if (fill < WINDOW_MAX) fill++;
          // A lowered window only trims the history here, on the next measurement.
          if (fill > limit) fill = limit;
        end
        want.average = weighted_avg();
        want.held    = FILL_W'(fill);
        expected_words.push_back(want);
      end

      pending_o <= expected_words.size();
      errors_o  <= fail_count;
    end
  end

endmodule

[tb/tb_top.sv]
// Top of the decayed window average testbench: clock, reset, stimulus and the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dwa_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 64;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int FIXED_PHASES    = 7;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  in_word_t             in_word    = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  out_word_t            out_word;
  logic                 calm       = 1'b0;
  int                   pending;
  int                   errors;
  int                   stall_cycles = 0;

  // Fixed settings first: default, narrowest, zero, oversized, lowered, full, lowered again.
  int unsigned wl_plan    [FIXED_PHASES] = '{16, 1, 0, 31, 8, 16, 5};
  int unsigned decay_plan [FIXED_PHASES] = '{32768, 0, 12345, 65535, 16384, 32767, 32768};

  decayed_window_average i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  dwa_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_word(input logic cmd, input logic [SAMPLE_BITS-1:0] smp);
    in_word_t word;
    word.command = cmd;
    word.sample  = smp;
    in_valid <= 1'b1;
    in_word  <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits until every result word has been read and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input int unsigned wl, input int unsigned dc);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_LENGTH;
    cfg_data  <= CFG_W'(wl);
    @(posedge clk);
    cfg_index <= REG_DECAY;
    cfg_data  <= CFG_W'(dc);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int count);
    logic                   cmd;
    logic [SAMPLE_BITS-1:0] smp;
    int                     pick;
    for (int i = 0; i < count; i++) begin
      cmd  = ($urandom_range(99) < 7) ? CMD_CLEAR : CMD_MEASURE;
      pick = $urandom_range(7);
      if (pick == 0)      smp = 16'h7fff;
      else if (pick == 1) smp = 16'h8000;
      else                smp = SAMPLE_BITS'($urandom);
      if (!calm) begin
        pick = $urandom_range(99);
        // Mostly short gaps, now and then one long enough to land anywhere in a computation.
        if (pick < 20) begin
          in_valid         <= 1'b0;
          in_word.command  <= 1'($urandom_range(1));
          in_word.sample   <= SAMPLE_BITS'($urandom);
          repeat (pick < 16 ? $urandom_range(1, 3) : $urandom_range(4, 48)) @(posedge clk);
        end
      end
      send_word(cmd, smp);
    end
  endtask

  initial begin
    int unsigned wl;
    int unsigned dc;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: clear on an empty window, fill past the top, extremes and sign bits.
    send_word(CMD_CLEAR, 16'h5a5a);
    repeat (17) send_word(CMD_MEASURE, 16'h7fff);
    send_word(CMD_MEASURE, 16'h8000);
    send_word(CMD_MEASURE, 16'h0000);
    send_word(CMD_MEASURE, 16'h0001);
    send_word(CMD_MEASURE, 16'hffff);
    send_word(CMD_CLEAR, 16'ha5a5);
    repeat (2) send_word(CMD_MEASURE, 16'h8000);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p < FIXED_PHASES) begin
        wl = wl_plan[p];
        dc = decay_plan[p];
      end else begin
        wl = ($urandom_range(4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        dc = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(24576, 32768);
      end
      load_config(wl, dc);
      calm <= (p == 3 || p == 4);
      run_random(ITEMS_PER_PHASE);
    end

    settle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
